@@ src/itp_pkg.sv @@
`timescale 1ns / 1ps

package itp_pkg;

    localparam int CH_W       = 8;
    localparam int BASE_W     = 6;
    localparam int VALUE_W    = 64;
    localparam int CONS_W     = 16;
    localparam int TDATA_W    = VALUE_W + CONS_W;
    localparam int TUSER_W    = 2;

    localparam int unsigned MAX_LENGTH = 65535;
    localparam int POS_W = $clog2(MAX_LENGTH + 1);

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

    typedef struct packed {
        logic                      overflow;
        logic                      formed;
        logic [CONS_W-1:0]         consumed;
        logic signed [VALUE_W-1:0] value;
    } t_result;

endpackage

@@ src/itp_core.sv @@
`timescale 1ns / 1ps

module itp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_advance,
    input  logic [itp_pkg::CH_W-1:0]      i_ch,
    input  logic [itp_pkg::BASE_W-1:0]    i_base,
    output logic                          o_emit,
    output itp_pkg::t_result              o_result
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_ZEROX  = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;

    localparam logic [itp_pkg::CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [itp_pkg::CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [itp_pkg::CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [itp_pkg::CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [itp_pkg::CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [itp_pkg::CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [itp_pkg::CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [itp_pkg::CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [itp_pkg::CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [itp_pkg::CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [itp_pkg::CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [itp_pkg::CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [itp_pkg::CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [itp_pkg::CH_W-1:0] CH_UX    = 8'h58;

    localparam logic [itp_pkg::BASE_W-1:0] NO_DIGIT = '1;
    localparam logic [itp_pkg::BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [itp_pkg::BASE_W-1:0] BASE_MAX = 6'd36;
    localparam logic [itp_pkg::BASE_W-1:0] BASE_DEC = 6'd10;
    localparam logic [itp_pkg::BASE_W-1:0] BASE_OCT = 6'd8;
    localparam logic [itp_pkg::BASE_W-1:0] BASE_HEX = 6'd16;

    localparam int MAC_W = itp_pkg::VALUE_W + itp_pkg::BASE_W + 1;

    localparam logic [itp_pkg::VALUE_W-1:0] POS_LIMIT = {1'b0, {(itp_pkg::VALUE_W-1){1'b1}}};
    localparam logic [itp_pkg::VALUE_W-1:0] NEG_LIMIT = {1'b1, {(itp_pkg::VALUE_W-1){1'b0}}};

    // letters of either case count as digits above 9, anything else never beats a radix
    function automatic logic [itp_pkg::BASE_W-1:0] digit_of(input logic [itp_pkg::CH_W-1:0] c);
        logic [itp_pkg::BASE_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = itp_pkg::BASE_W'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = itp_pkg::BASE_W'(c - CH_LA) + BASE_DEC;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = itp_pkg::BASE_W'(c - CH_UA) + BASE_DEC;
        end
        return d;
    endfunction

    logic [2:0]                      r_phase, n_phase;
    logic [itp_pkg::VALUE_W-1:0]     r_acc, n_acc;
    logic                            r_neg, n_neg;
    logic [itp_pkg::BASE_W-1:0]      r_base, n_base;
    logic [itp_pkg::POS_W-1:0]       r_pos, n_pos;
    logic                            r_ovf, n_ovf;

    logic [2:0]                      e_phase;
    logic [itp_pkg::VALUE_W-1:0]     e_acc;
    logic                            e_neg;
    logic [itp_pkg::BASE_W-1:0]      e_base;
    logic                            e_ovf;

    logic [itp_pkg::BASE_W-1:0]      dig;
    logic [itp_pkg::BASE_W-1:0]      fb;
    logic [itp_pkg::BASE_W-1:0]      dbase;
    logic                            use_digits;
    logic                            emit;
    logic                            formed;
    logic [itp_pkg::CONS_W-1:0]      cons;
    logic                            is_space;
    logic [MAC_W-2:0]                prod;
    logic [MAC_W-1:0]                mac;
    logic [itp_pkg::VALUE_W-1:0]     limit;
    logic                            mac_ovf;
    logic [itp_pkg::VALUE_W-1:0]     mag;

    always_comb begin
        // the first character of a string starts from a clean state
        if (r_phase == PH_START) begin
            e_phase = PH_LEAD;
            e_acc   = '0;
            e_neg   = 1'b0;
            e_base  = i_base;
            e_ovf   = 1'b0;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_neg   = r_neg;
            e_base  = r_base;
            e_ovf   = r_ovf;
        end

        dig        = digit_of(i_ch);
        is_space   = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
        n_phase    = e_phase;
        n_acc      = e_acc;
        n_neg      = e_neg;
        n_base     = e_base;
        n_ovf      = e_ovf;
        fb         = e_base;
        dbase      = e_base;
        use_digits = 1'b0;
        emit       = 1'b0;
        formed     = 1'b0;
        cons       = itp_pkg::CONS_W'(r_pos);

        unique case (e_phase)
            PH_LEAD, PH_SIGNED: begin
                if (e_phase == PH_LEAD && is_space) begin
                    n_phase = e_phase;
                end else if (e_phase == PH_LEAD && i_ch == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (e_phase == PH_LEAD && i_ch == CH_PLUS) begin
                    n_phase = PH_SIGNED;
                end else if (e_base == '0 && i_ch == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else begin
                    if (e_base == '0) begin
                        fb = BASE_DEC;
                    end
                    n_base = fb;
                    if (fb < BASE_MIN || fb > BASE_MAX) begin
                        emit = 1'b1;
                    end else if (fb == BASE_HEX && i_ch == CH_ZERO) begin
                        n_phase = PH_ZERO;
                    end else if (dig >= fb) begin
                        emit = 1'b1;
                    end else begin
                        n_acc   = itp_pkg::VALUE_W'(dig);
                        n_phase = PH_DIGITS;
                    end
                end
            end
            PH_ZERO: begin
                if (i_ch == CH_LX || i_ch == CH_UX) begin
                    if (e_base == '0) begin
                        n_base = BASE_HEX;
                    end
                    n_phase = PH_ZEROX;
                end else begin
                    if (e_base == '0) begin
                        dbase = BASE_OCT;
                    end
                    n_base     = dbase;
                    n_phase    = PH_DIGITS;
                    use_digits = 1'b1;
                end
            end
            PH_ZEROX: begin
                // a lone 0x ends the number at the zero
                if (dig < BASE_HEX) begin
                    n_acc   = itp_pkg::VALUE_W'(dig);
                    n_phase = PH_DIGITS;
                end else begin
                    emit   = 1'b1;
                    formed = 1'b1;
                    cons   = (r_pos == '0) ? '0 : itp_pkg::CONS_W'(r_pos - 1'b1);
                end
            end
            PH_DIGITS: begin
                use_digits = 1'b1;
            end
            default: begin
                n_phase = e_phase;
            end
        endcase

        // overflow when acc * base + d passes the limit, same as the strtol cutoff test
        prod    = (MAC_W-1)'(e_acc) * (MAC_W-1)'(dbase);
        mac     = MAC_W'(prod) + MAC_W'(dig);
        limit   = e_neg ? NEG_LIMIT : POS_LIMIT;
        mac_ovf = mac > MAC_W'(limit);

        if (use_digits) begin
            if (dig < dbase) begin
                if (!e_ovf) begin
                    if (mac_ovf) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = mac[itp_pkg::VALUE_W-1:0];
                    end
                end
            end else begin
                emit   = 1'b1;
                formed = 1'b1;
            end
        end

        if (emit) begin
            n_phase = PH_SKIP;
        end

        if (i_ch == CH_NUL) begin
            n_phase = PH_START;
            n_pos   = '0;
        end else if (r_pos != itp_pkg::POS_W'(itp_pkg::MAX_LENGTH)) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_pos = r_pos;
        end

        mag = e_neg ? (~e_acc + 1'b1) : e_acc;
        o_emit            = i_valid && emit;
        o_result.formed   = formed;
        o_result.overflow = formed && e_ovf;
        o_result.consumed = formed ? cons : '0;
        if (!formed) begin
            o_result.value = '0;
        end else if (e_ovf) begin
            o_result.value = limit;
        end else begin
            o_result.value = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_ovf   <= n_ovf;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_then_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_emit && i_ch != CH_NUL) |=> (r_phase == PH_SKIP))
        else $error("number ended but parser did not move to skip");

    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_ch == CH_NUL) |=> (r_phase == PH_START && r_pos == '0))
        else $error("end of string did not restart the parser");

    a_ovf_formed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.overflow) |-> o_result.formed)
        else $error("overflow flagged without a number");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && r_phase != PH_START && !(i_advance && i_ch == CH_NUL))
            |=> (r_ovf && $stable(r_acc)))
        else $error("accumulator moved after overflow");
`endif

endmodule

@@ src/itp_out_buf.sv @@
`timescale 1ns / 1ps

module itp_out_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  itp_pkg::t_result              i_result,
    input  logic                          i_m_axis_tready,
    output logic                          o_m_axis_tvalid,
    output logic [itp_pkg::TDATA_W-1:0]   o_m_axis_tdata,   // value, consumed
    output logic [itp_pkg::TUSER_W-1:0]   o_m_axis_tuser    // formed, overflow
);

    logic             r_valid;
    itp_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_result.consumed, r_result.value};
    assign o_m_axis_tuser  = {r_result.overflow, r_result.formed};

endmodule

@@ src/integer_text_parser_top.sv @@
`timescale 1ns / 1ps

// strtol-style integer parser, one character per word
// slave stream: tdata carries one character, NUL ends the string
// master stream: one word per string, sent at the character that ends the
//   number (first non-digit or NUL); tdata = value[63:0], consumed[79:64],
//   tuser = formed[0], overflow[1]; overflow saturates the value
// config channel: cfg_data is the radix (2..36, or 0 to detect from the
//   prefix), latched at the first character of each string; write it only
//   while the parser is idle; reset value is 10
// result path: the ending character is accepted into the input register and the
//   step logic writes the result register when that character advances, so
//   tvalid comes from the result register and the word waits there for tready
// throughput: one character per cycle unless the output stalls; the step is one
//   64x6 multiply-add with a limit compare between the input and result registers
// stall: while a result waits in the output register, characters that end
//   no number keep flowing; one that would produce a result holds in the
//   input register and tready drops until the master side takes the word
// reset (synchronous, active low) empties both registers and starts a new string

module integer_text_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [itp_pkg::CH_W-1:0]      i_s_axis_tdata,   // ch
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [itp_pkg::TDATA_W-1:0]   o_m_axis_tdata,   // value, consumed
    output logic [itp_pkg::TUSER_W-1:0]   o_m_axis_tuser,   // formed, overflow
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [itp_pkg::BASE_W-1:0]    i_cfg_data        // number_base
);

    logic                        r_in_valid;
    logic [itp_pkg::CH_W-1:0]    r_ch;
    logic [itp_pkg::BASE_W-1:0]  r_base;
    logic                        advance;
    logic                        emit;
    itp_pkg::t_result            result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= itp_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    // the word in the input register moves on unless its result would hit a full, stalled output
    assign advance = r_in_valid && (!emit || !o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_ch <= i_s_axis_tdata;
        end
    end

    itp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_advance (advance),
        .i_ch      (r_ch),
        .i_base    (r_base),
        .o_emit    (emit),
        .o_result  (result)
    );

    itp_out_buf u_out_buf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (advance && emit),
        .i_result        (result),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_ch)))
        else $error("pending character lost while output stalled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register overwritten before it was taken");
`endif

endmodule
